@@ sv/tfrp_pkg.sv @@
// Shared types, byte codes and helper functions for the tagged field record parser.
// No dependencies; every other file in sv/ imports this package.
package tfrp_pkg;

   // Capacities of the image value stream and of the record slot ring.
   localparam int MAX_PIXELS = 8192;
   localparam int DICT_SLOTS = 32;

   localparam int PIX_POS_W  = $clog2(MAX_PIXELS + 1);
   localparam int SLOT_PTR_W = $clog2(DICT_SLOTS);

   // Widths of the result fields.
   localparam int PIX_IDX_W = 13;
   localparam int PIX_VAL_W = 10;
   localparam int SLOT_W    = 5;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Digit limits of the numeric fields.
   localparam logic [2:0] SIZE_MAX_DIGITS  = 3'd4;
   localparam logic [1:0] DIM_MAX_DIGITS   = 2'd3;
   localparam logic [1:0] PIXEL_MAX_DIGITS = 2'd3;
   localparam logic [2:0] WORD_MAX_CHARS   = 3'd5;
   localparam logic [2:0] TYPE_MAX_CHARS   = 3'd4;

   // Byte codes.
   localparam logic [7:0] CH_WORD   = 8'h7C;  // '|'
   localparam logic [7:0] CH_IMAGE  = 8'h2F;  // '/'
   localparam logic [7:0] CH_TYPE   = 8'h24;  // '$'
   localparam logic [7:0] CH_SIZE   = 8'h2A;  // '*'
   localparam logic [7:0] CH_WIDTH  = 8'h23;  // '#'
   localparam logic [7:0] CH_HEIGHT = 8'h21;  // '!'
   localparam logic [7:0] CH_END    = 8'h25;  // '%'
   localparam logic [7:0] CH_SKIP   = 8'h2B;  // '+'
   localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   typedef enum logic [6:0] {
      FS_IDLE   = 7'b0000001,
      FS_WORD   = 7'b0000010,
      FS_IMAGE  = 7'b0000100,
      FS_TYPE   = 7'b0001000,
      FS_SIZE   = 7'b0010000,
      FS_WIDTH  = 7'b0100000,
      FS_HEIGHT = 7'b1000000
   } field_type;

   typedef struct packed {
      logic                 kind;
      logic [PIX_IDX_W-1:0] pixel_index;
      logic [PIX_VAL_W-1:0] pixel_value;
      logic [7:0]           img_height;
      logic [7:0]           img_width;
      logic [13:0]          img_size;
      logic [31:0]          type_chars;
      logic [39:0]          word_chars;
      logic [SLOT_W-1:0]    slot;
      logic                 last;
   } result_type;

   // Results produced by one byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // acc * 10 + digit value; for an ASCII digit the value is its low nibble.
   function automatic logic [13:0] mul10_add(input logic [13:0] acc, input logic [7:0] b);
      return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, b[3:0]};
   endfunction

   function automatic logic [7:0] sat255(input logic [9:0] v);
      return (v > 10'd255) ? 8'd255 : v[7:0];
   endfunction

endpackage

@@ sv/tfrp_parse.sv @@
// Parse state and the per-byte field update; produces up to two results per byte.
// Depends on tfrp_pkg.
module tfrp_parse import tfrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] rx_byte,
   output push_type   push
);

   field_type              field_ff, field_in;
   logic [39:0]            word_ff, word_in;
   logic [2:0]             word_cnt_ff, word_cnt_in;
   logic [31:0]            type_ff, type_in;
   logic [2:0]             type_cnt_ff, type_cnt_in;
   logic [13:0]            size_ff, size_in;
   logic [2:0]             size_dig_ff, size_dig_in;
   logic [9:0]             width_ff, width_in;
   logic [1:0]             width_dig_ff, width_dig_in;
   logic [9:0]             height_ff, height_in;
   logic [1:0]             height_dig_ff, height_dig_in;
   logic [9:0]             pix_ff, pix_in;
   logic [1:0]             pix_dig_ff, pix_dig_in;
   logic [PIX_POS_W-1:0]   pos_ff, pos_in;
   logic [SLOT_PTR_W-1:0]  slot_ptr_ff, slot_ptr_in;

   logic       digit;
   logic       pix_fits;
   result_type pix_res;
   result_type rec_res;

   assign digit    = is_digit(rx_byte);
   assign pix_fits = (pos_ff < PIX_POS_W'(MAX_PIXELS));

   always_comb begin
      pix_res             = '0;
      pix_res.kind        = KIND_PIXEL;
      pix_res.pixel_index = PIX_IDX_W'(pos_ff);
      pix_res.pixel_value = pix_ff;

      rec_res            = '0;
      rec_res.kind       = KIND_RECORD;
      rec_res.img_height = sat255(height_ff);
      rec_res.img_width  = sat255(width_ff);
      rec_res.img_size   = size_ff;
      rec_res.type_chars = type_ff;
      rec_res.word_chars = word_ff;
      rec_res.slot       = SLOT_W'(slot_ptr_ff);
      rec_res.last       = 1'b1;
   end

   always_comb begin
      field_in      = field_ff;
      word_in       = word_ff;
      word_cnt_in   = word_cnt_ff;
      type_in       = type_ff;
      type_cnt_in   = type_cnt_ff;
      size_in       = size_ff;
      size_dig_in   = size_dig_ff;
      width_in      = width_ff;
      width_dig_in  = width_dig_ff;
      height_in     = height_ff;
      height_dig_in = height_dig_ff;
      pix_in        = pix_ff;
      pix_dig_in    = pix_dig_ff;
      pos_in        = pos_ff;
      slot_ptr_in   = slot_ptr_ff;
      push          = '0;

      unique case (rx_byte)
         CH_SKIP: ;
         CH_WORD:   field_in = FS_WORD;
         CH_IMAGE:  field_in = FS_IMAGE;
         CH_TYPE:   field_in = FS_TYPE;
         CH_SIZE:   field_in = FS_SIZE;
         CH_WIDTH:  field_in = FS_WIDTH;
         CH_HEIGHT: field_in = FS_HEIGHT;
         CH_END: begin
            // A token holding any byte is flushed ahead of the record while the image is below MAX_PIXELS.
            if ((pix_dig_ff != 2'd0) && pix_fits) begin
               push.count  = 2'd2;
               push.first  = pix_res;
               push.second = rec_res;
            end else begin
               push.count = 2'd1;
               push.first = rec_res;
            end
            if (slot_ptr_ff == SLOT_PTR_W'(DICT_SLOTS - 1)) begin
               slot_ptr_in = '0;
            end else begin
               slot_ptr_in = slot_ptr_ff + 1'b1;
            end
            field_in      = FS_IDLE;
            word_in       = '0;
            word_cnt_in   = '0;
            type_in       = '0;
            type_cnt_in   = '0;
            size_in       = '0;
            size_dig_in   = '0;
            width_in      = '0;
            width_dig_in  = '0;
            height_in     = '0;
            height_dig_in = '0;
            pix_in        = '0;
            pix_dig_in    = '0;
            pos_in        = '0;
         end
         default: begin
            unique case (field_ff)
               FS_IDLE: ;
               FS_WORD: begin
                  if (word_cnt_ff < WORD_MAX_CHARS) begin
                     word_in[{word_cnt_ff, 3'b000} +: 8] = rx_byte;
                     word_cnt_in = word_cnt_ff + 3'd1;
                  end
               end
               FS_IMAGE: begin
                  if (rx_byte == CH_COMMA) begin
                     if (pix_fits) begin
                        push.count      = 2'd1;
                        push.first      = pix_res;
                        push.first.last = 1'b1;
                        pos_in          = pos_ff + 1'b1;
                     end
                     pix_in     = '0;
                     pix_dig_in = '0;
                  end else if (pix_dig_ff < PIXEL_MAX_DIGITS) begin
                     if (digit) begin
                        pix_in     = 10'(mul10_add({4'd0, pix_ff}, rx_byte));
                        pix_dig_in = pix_dig_ff + 2'd1;
                     end else begin
                        pix_dig_in = PIXEL_MAX_DIGITS;
                     end
                  end
               end
               FS_TYPE: begin
                  if (type_cnt_ff < TYPE_MAX_CHARS) begin
                     type_in[{type_cnt_ff[1:0], 3'b000} +: 8] = rx_byte;
                     type_cnt_in = type_cnt_ff + 3'd1;
                  end
               end
               FS_SIZE: begin
                  if (size_dig_ff < SIZE_MAX_DIGITS) begin
                     if (digit) begin
                        size_in     = mul10_add(size_ff, rx_byte);
                        size_dig_in = size_dig_ff + 3'd1;
                     end else begin
                        size_dig_in = SIZE_MAX_DIGITS;
                     end
                  end
               end
               FS_WIDTH: begin
                  if (width_dig_ff < DIM_MAX_DIGITS) begin
                     if (digit) begin
                        width_in     = 10'(mul10_add({4'd0, width_ff}, rx_byte));
                        width_dig_in = width_dig_ff + 2'd1;
                     end else begin
                        width_dig_in = DIM_MAX_DIGITS;
                     end
                  end
               end
               FS_HEIGHT: begin
                  if (height_dig_ff < DIM_MAX_DIGITS) begin
                     if (digit) begin
                        height_in     = 10'(mul10_add({4'd0, height_ff}, rx_byte));
                        height_dig_in = height_dig_ff + 2'd1;
                     end else begin
                        height_dig_in = DIM_MAX_DIGITS;
                     end
                  end
               end
               default: ;
            endcase
         end
      endcase

      if (!go) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff      <= FS_IDLE;
         word_ff       <= '0;
         word_cnt_ff   <= '0;
         type_ff       <= '0;
         type_cnt_ff   <= '0;
         size_ff       <= '0;
         size_dig_ff   <= '0;
         width_ff      <= '0;
         width_dig_ff  <= '0;
         height_ff     <= '0;
         height_dig_ff <= '0;
         pix_ff        <= '0;
         pix_dig_ff    <= '0;
         pos_ff        <= '0;
         slot_ptr_ff   <= '0;
      end else if (go) begin
         field_ff      <= field_in;
         word_ff       <= word_in;
         word_cnt_ff   <= word_cnt_in;
         type_ff       <= type_in;
         type_cnt_ff   <= type_cnt_in;
         size_ff       <= size_in;
         size_dig_ff   <= size_dig_in;
         width_ff      <= width_in;
         width_dig_ff  <= width_dig_in;
         height_ff     <= height_in;
         height_dig_ff <= height_dig_in;
         pix_ff        <= pix_in;
         pix_dig_ff    <= pix_dig_in;
         pos_ff        <= pos_in;
         slot_ptr_ff   <= slot_ptr_in;
      end
   end

   // The end byte always returns the parser to idle with an empty word.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      go && (rx_byte == CH_END) |=> (field_ff == FS_IDLE) && (word_cnt_ff == 3'd0))
      else $error("end byte did not clear the parse state");

   // Every record moves the slot ring on.
   a_slot_moves: assert property (@(posedge clock) disable iff (reset)
      go && (rx_byte == CH_END) |=> !$stable(slot_ptr_ff))
      else $error("slot pointer did not advance on a record");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (word_cnt_ff <= WORD_MAX_CHARS) && (type_cnt_ff <= TYPE_MAX_CHARS)
      && (size_dig_ff <= SIZE_MAX_DIGITS) && (pos_ff <= PIX_POS_W'(MAX_PIXELS)))
      else $error("parse counter out of range");

endmodule

@@ sv/tfrp_out_queue.sv @@
// Small result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// Depends on tfrp_pkg.
module tfrp_out_queue import tfrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QIDX_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [QIDX_W-1:0] tail_next;

   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + QIDX_W'(push.count);
      count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed without room");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

endmodule

@@ sv/tagged_field_record_parser.sv @@
// Top level of the tagged field record parser: input register, parser and result queue.
// Depends on tfrp_pkg, tfrp_parse and tfrp_out_queue.
//
// The block takes one received byte per item and accepts a new item in every clock
// cycle while results are being taken. An accepted byte is held in an input register
// until the queue has room; the parser then updates its field state and writes the
// results that the byte causes into a four-entry result queue, from whose registers
// they reach the rsp_ ports. Most bytes cause no result, a comma in the image field
// causes one pixel result while the image is below MAX_PIXELS, and the end byte causes
// a record result, preceded by a pixel result when a value is still pending and fits.
// The rsp_ side delivers one result per cycle while rsp_ready is high, so a stream
// that produces more results than bytes is paced by the result port; the input
// register moves on only when the queue has room for two results. Marker bytes pick
// the field; '+' is skipped; numeric fields freeze at their first non-digit; width
// and height are reported saturated at 255.
module tagged_field_record_parser import tfrp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [PIX_IDX_W-1:0] rsp_pixel_index,
   output logic [PIX_VAL_W-1:0] rsp_pixel_value,
   output logic [7:0]           rsp_img_height,
   output logic [7:0]           rsp_img_width,
   output logic [13:0]          rsp_img_size,
   output logic [31:0]          rsp_type_chars,
   output logic [39:0]          rsp_word_chars,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       room;
   logic       advance;
   push_type   push;
   result_type head;

   // The held byte is processed in the cycle the queue can take both of its results.
   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   tfrp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .go      (advance),
      .rx_byte (in_byte_ff),
      .push    (push)
   );

   tfrp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_pixel_index = head.pixel_index;
   assign rsp_pixel_value = head.pixel_value;
   assign rsp_img_height  = head.img_height;
   assign rsp_img_width   = head.img_width;
   assign rsp_img_size    = head.img_size;
   assign rsp_type_chars  = head.type_chars;
   assign rsp_word_chars  = head.word_chars;
   assign rsp_slot        = head.slot;
   assign rsp_last        = head.last;

   // An end byte always yields a result, and the last one it yields is the record.
   a_end_yields_record: assert property (@(posedge clock) disable iff (reset)
      advance && (in_byte_ff == CH_END) |->
         (push.count != 2'd0)
         && ((push.count == 2'd1) ? push.first.kind : push.second.kind) == KIND_RECORD)
      else $error("end byte without a record result");

   // Nothing reaches the queue unless a held byte is being processed.
   a_push_needs_byte: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> advance)
      else $error("result pushed without a byte");

   a_byte_taken: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted byte not held");

endmodule
